### src/fifo_queue_with_search_and_update_defines.svh
// assertion macros shared by the fifo queue rtl
`ifndef FIFO_QUEUE_WITH_SEARCH_AND_UPDATE_DEFINES_SVH
`define FIFO_QUEUE_WITH_SEARCH_AND_UPDATE_DEFINES_SVH

// condition implies consequence in the same cycle
`define FQSU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define FQSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/fqsu_pkg.sv
// types and constants of the fifo queue with search and update
`timescale 1ns / 1ps

package fqsu_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W  = 7;

	// command codes carried in the input tuser
	typedef enum logic [1:0] {
		CMD_PUSH   = 2'd0,
		CMD_POP    = 2'd1,
		CMD_MODIFY = 2'd2,
		CMD_FIND   = 2'd3
	} cmd_t;

	// result status codes carried in the output tuser
	typedef enum logic [2:0] {
		STAT_OK      = 3'd0,
		STAT_EMPTY   = 3'd1,
		STAT_FULL    = 3'd2,
		STAT_BADPOS  = 3'd3,
		STAT_NOMATCH = 3'd4
	} stat_t;

	// controller states
	typedef enum logic {
		S_IDLE = 1'b0,
		S_SCAN = 1'b1
	} state_t;

	// per-cell control from the controller
	typedef struct packed {
		logic load;     // write the incoming word
		logic shift;    // take the word of the neighbor toward the tail
		logic capture;  // register the compare against the key
	} cell_ctrl_t;

endpackage

### src/fifo_queue_with_search_and_update.sv
// top level of the fifo queue with search and update
//
//  channel | direction | tdata (low bit up)                  | tuser  | tlast
//  s_*     | in        | value[31:0], position[38:32], pad   | cmd    | -
//  m_*     | out       | data_out[31:0], match_position[38:32], pad | status | last
//
// for push, pop and modify the transaction is accepted and its
// result lands in the output register at the same edge.
// find compares all cells at once into registered match flags, then walks the
// match flags one cell per cycle while the output is free, up to the last match.
// a stalled output holds the walk and blocks new input; reset empties the
// queue at once, cell words keep whatever they held.
`timescale 1ns / 1ps

module fifo_queue_with_search_and_update
	import fqsu_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // value[31:0], position[38:32], zero pad
	input  logic [1:0]  s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // data_out[31:0], match_position[38:32], zero pad
	output logic [2:0]  m_tuser,   // status
	output logic        m_tlast
);

	`include "fifo_queue_with_search_and_update_defines.svh"

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	state_t            state_q, state_nxt;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  scan_q;

	logic              out_valid_q;
	stat_t             out_stat_q;
	logic [DATA_W-1:0] out_data_q;
	logic [POS_W-1:0]  out_pos_q;
	logic              out_last_q;

	logic              load_out;
	stat_t             stat_nxt;
	logic [DATA_W-1:0] data_nxt;
	logic [POS_W-1:0]  pos_nxt;
	logic              last_nxt;

	cmd_t              cmd;
	logic [DATA_W-1:0] key;
	logic [POS_W-1:0]  pos;
	logic              accept;
	logic              out_free;
	logic              full;
	logic              empty;
	logic              pos_ok;
	logic [IDX_W-1:0]  push_sel;
	logic [IDX_W-1:0]  mod_sel;
	logic [DATA_W-1:0] old_data;

	cell_ctrl_t        ctrl    [DEPTH];
	logic [DATA_W-1:0] cell_data [DEPTH];
	logic [DEPTH-1:0]  match_vec;
	logic [DEPTH-1:0]  above;
	logic              cur_match;
	logic              any_match;
	logic              more;
	logic              scan_emit;
	logic              scan_done;

	// input decode
	assign cmd      = cmd_t'(s_tuser);
	assign key      = s_tdata[31:0];
	assign pos      = s_tdata[38:32];
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pos_ok   = (pos != '0) && (pos <= POS_W'(count_q));
	assign push_sel = count_q[IDX_W-1:0];
	assign mod_sel  = IDX_W'(pos - POS_W'(1));

	// old word at the modify position
	always_comb begin
		old_data = '0;
		for (int k = 0; k < DEPTH; k++) begin
			if (mod_sel == IDX_W'(k)) begin
				old_data = cell_data[k];
			end
		end
	end

	// per-cell control
	always_comb begin
		for (int k = 0; k < DEPTH; k++) begin
			ctrl[k].load = accept && (
				(cmd == CMD_PUSH && !full && push_sel == IDX_W'(k)) ||
				(cmd == CMD_MODIFY && pos_ok && mod_sel == IDX_W'(k)));
			ctrl[k].shift   = accept && (cmd == CMD_POP) && !empty;
			ctrl[k].capture = accept && (cmd == CMD_FIND);
		end
	end

	// the chain of cells, head at cell zero
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		fqsu_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl[g]),
			.wdata     (key),
			.next_data ((g == DEPTH - 1) ? cell_data[g] : cell_data[(g + 1) % DEPTH]),
			.key       (key),
			.live      (CNT_W'(g) < count_q),
			.data      (cell_data[g]),
			.match     (match_vec[g])
		);
	end

	// scan of the match flags
	always_comb begin
		for (int k = 0; k < DEPTH; k++) begin
			above[k] = match_vec[k] && (IDX_W'(k) > scan_q);
		end
	end

	assign cur_match = match_vec[scan_q];
	assign any_match = |match_vec;
	assign more      = |above;
	assign scan_emit = (state_q == S_SCAN) && out_free && (!any_match || cur_match);
	assign scan_done = (state_q == S_SCAN) && out_free && (!any_match || (cur_match && !more));

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && cmd == CMD_FIND) begin
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// outputs of the controller
	always_comb begin
		s_tready = 1'b0;
		load_out = 1'b0;
		stat_nxt = STAT_OK;
		data_nxt = '0;
		pos_nxt  = '0;
		last_nxt = 1'b1;
		case (state_q)
			S_IDLE: begin
				s_tready = out_free;
				if (accept) begin
					case (cmd)
						CMD_PUSH: begin
							load_out = 1'b1;
							stat_nxt = full ? STAT_FULL : STAT_OK;
						end
						CMD_POP: begin
							load_out = 1'b1;
							stat_nxt = empty ? STAT_EMPTY : STAT_OK;
							data_nxt = empty ? '0 : cell_data[0];
						end
						CMD_MODIFY: begin
							load_out = 1'b1;
							stat_nxt = pos_ok ? STAT_OK : STAT_BADPOS;
							data_nxt = pos_ok ? old_data : '0;
						end
						default: load_out = 1'b0;
					endcase
				end
			end
			S_SCAN: begin
				if (scan_emit) begin
					load_out = 1'b1;
					if (!any_match) begin
						stat_nxt = STAT_NOMATCH;
					end else begin
						pos_nxt  = POS_W'(scan_q) + POS_W'(1);
						last_nxt = !more;
					end
				end
			end
			default: s_tready = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept && cmd == CMD_PUSH && !full) begin
				count_q <= count_q + CNT_W'(1);
			end else if (accept && cmd == CMD_POP && !empty) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (accept && cmd == CMD_FIND) begin
				scan_q <= '0;
			end else if (state_q == S_SCAN && out_free && !scan_done) begin
				scan_q <= scan_q + IDX_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_stat_q <= stat_nxt;
			out_data_q <= data_nxt;
			out_pos_q  <= pos_nxt;
			out_last_q <= last_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_pos_q, out_data_q};
	assign m_tuser  = out_stat_q;
	assign m_tlast  = out_last_q;

	// checks
	`FQSU_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(DEPTH),
		"entry count above depth")
	`FQSU_ASSERT_NEXT(a_push_grows, clk, arst_n, accept && cmd == CMD_PUSH && !full,
		count_q == $past(count_q) + CNT_W'(1), "push did not grow the queue")
	`FQSU_ASSERT_SAME(a_scan_blocks_input, clk, arst_n, state_q == S_SCAN, !s_tready,
		"input taken during a find scan")
	`FQSU_ASSERT_SAME(a_nomatch_form, clk, arst_n, out_valid_q && out_stat_q == STAT_NOMATCH,
		out_last_q && out_pos_q == '0, "no-match result not final or has a position")

endmodule

### src/fqsu_cell.sv
// one storage cell of the queue chain with its key comparator
`timescale 1ns / 1ps

module fqsu_cell
	import fqsu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctrl_t        ctrl,
	input  logic [DATA_W-1:0] wdata,
	input  logic [DATA_W-1:0] next_data,
	input  logic [DATA_W-1:0] key,
	input  logic              live,
	output logic [DATA_W-1:0] data,
	output logic              match
);

	logic [DATA_W-1:0] data_q;
	logic              match_q;

	// stored word: load wins, else shift from the tail-side neighbor
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= wdata;
		end else if (ctrl.shift) begin
			data_q <= next_data;
		end
	end

	// match flag for the find scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.capture) begin
			match_q <= live && (data_q == key);
		end
	end

	assign data  = data_q;
	assign match = match_q;

endmodule

### test/tb.sv
// testbench of the fifo queue with search and update: random commands, queue predictor, checker
`timescale 1ns / 1ps

module tb;
	import fqsu_pkg::*;

	localparam int QDEPTH = 16;
	localparam int NUM_RANDOM = 440;

	// one command waiting to be sent; hold_for_drain waits for all results first
	typedef struct {
		cmd_t        cmd;
		logic [31:0] value;
		logic [6:0]  position;
		bit          hold_for_drain;
	} queue_cmd_t;

	// one expected result transaction
	typedef struct packed {
		stat_t       status;
		logic [31:0] data_out;
		logic [6:0]  match_pos;
		logic        last;
	} queue_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;    // value[31:0], position[38:32], zero pad
	logic [1:0]  s_tuser = '0;    // cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;         // data_out[31:0], match_position[38:32], zero pad
	logic [2:0]  m_tuser;         // status
	logic        m_tlast;

	queue_cmd_t          cmd_q[$];
	queue_result_t       expected_results[$];
	logic signed [31:0]  stored_words[$];
	queue_cmd_t          next_cmd;
	logic                results_pending = 1'b0;
	logic                drain_hold = 1'b0;
	logic [4:0]          send_gap = '0;
	logic [4:0]          recv_stall = '0;
	logic [15:0]         cycle_cnt = '0;
	int unsigned         fail_count = 0;
	int unsigned         gen_count = 0;

	// stretches of time with no idling on either side
	wire quiet = (cycle_cnt[8:7] == 2'b11);

	fifo_queue_with_search_and_update #(.DEPTH(QDEPTH)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// idle length: mostly short, a few long
	function automatic logic [4:0] idle_len();
		if ($urandom_range(99) < 85)
			return 5'($urandom_range(3, 1));
		return 5'($urandom_range(20, 6));
	endfunction

	// queue behavior: apply one accepted command and queue up its results
	function automatic void apply_command(cmd_t cmd, logic signed [31:0] value,
			logic [6:0] position);
		queue_result_t res;
		queue_result_t hits[$];
		res = '{STAT_OK, 32'd0, 7'd0, 1'b1};
		case (cmd)
			CMD_PUSH: begin
				if (stored_words.size() >= QDEPTH)
					res.status = STAT_FULL;
				else
					stored_words.push_back(value);
			end
			CMD_POP: begin
				if (stored_words.size() == 0)
					res.status = STAT_EMPTY;
				else
					res.data_out = stored_words.pop_front();
			end
			CMD_MODIFY: begin
				if (position == 0 || position > stored_words.size()) begin
					res.status = STAT_BADPOS;
				end else begin
					res.data_out = stored_words[position - 1];
					stored_words[position - 1] = value;
				end
			end
			default: begin
				foreach (stored_words[i]) begin
					if (stored_words[i] == value)
						hits.push_back('{STAT_OK, 32'd0, 7'(i + 1), 1'b0});
				end
				if (hits.size() == 0) begin
					res.status = STAT_NOMATCH;
				end else begin
					hits[hits.size() - 1].last = 1'b1;
					foreach (hits[i])
						expected_results.push_back(hits[i]);
					return;
				end
			end
		endcase
		expected_results.push_back(res);
	endfunction

	function automatic void compare_field(string name, longint expv, longint actv);
		if (expv != actv) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
			fail_count++;
		end
	endfunction

	// compare one output transaction with the oldest expectation
	function automatic void check_result();
		queue_result_t expv;
		if (expected_results.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual status %0d data %0d pos %0d",
				$time, m_tuser, $signed(m_tdata[31:0]), m_tdata[38:32]);
			fail_count++;
			return;
		end
		expv = expected_results.pop_front();
		compare_field("status", expv.status, m_tuser);
		compare_field("data_out", $signed(expv.data_out), $signed(m_tdata[31:0]));
		compare_field("match_position", expv.match_pos, m_tdata[38:32]);
		compare_field("last", expv.last, m_tlast);
	endfunction

	// driver: send commands with random gaps, hold some until all results are back
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tuser    <= CMD_PUSH;
			send_gap   <= '0;
			drain_hold <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (send_gap != 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1'b1;
			end else if (cmd_q.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (cmd_q[0].hold_for_drain && (!drain_hold || results_pending)) begin
				s_tvalid   <= 1'b0;
				drain_hold <= 1'b1;
			end else begin
				next_cmd   = cmd_q.pop_front();
				s_tvalid   <= 1'b1;
				s_tdata    <= {1'b0, next_cmd.position, next_cmd.value};
				s_tuser    <= next_cmd.cmd;
				drain_hold <= 1'b0;
				send_gap   <= (quiet || $urandom_range(99) < 50) ? 5'd0 : idle_len();
			end
		end
	end

	// monitor: check output transactions, predict input transactions, stall the output
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready        <= 1'b0;
			recv_stall      <= '0;
			results_pending <= 1'b0;
			cycle_cnt       <= '0;
		end else begin
			cycle_cnt <= cycle_cnt + 1'b1;
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready)
				apply_command(cmd_t'(s_tuser), $signed(s_tdata[31:0]), s_tdata[38:32]);
			results_pending <= (expected_results.size() != 0);
			if (recv_stall != 0) begin
				m_tready   <= 1'b0;
				recv_stall <= recv_stall - 1'b1;
			end else if (!quiet && $urandom_range(99) < 20) begin
				m_tready   <= 1'b0;
				recv_stall <= idle_len() - 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// stimulus and end of run
	initial begin : stimulus
		logic [31:0] key_pool[6];
		logic [31:0] val;
		int unsigned roll;
		int unsigned phase;
		cmd_t        cmd;
		logic [6:0]  pos;

		key_pool = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
			32'h5a5a_a5a5, 32'h0000_0011};

		// directed: empty queue cases
		add_cmd(CMD_FIND, 32'd0, 7'd0, 1'b0);
		add_cmd(CMD_POP, 32'd0, 7'd0, 1'b0);
		add_cmd(CMD_MODIFY, 32'd5, 7'd0, 1'b0);
		add_cmd(CMD_MODIFY, 32'd5, 7'd64, 1'b0);
		// extremes, then fill with one repeated word up to full
		for (int i = 0; i < 4; i++)
			add_cmd(CMD_PUSH, key_pool[i], 7'd0, 1'b0);
		for (int i = 0; i < QDEPTH - 4; i++)
			add_cmd(CMD_PUSH, 32'h5a5a_a5a5, 7'd0, 1'b0);
		add_cmd(CMD_PUSH, 32'd1, 7'd0, 1'b0);
		// many matches on a full queue, sent once everything is back
		add_cmd(CMD_FIND, 32'h5a5a_a5a5, 7'd0, 1'b1);
		add_cmd(CMD_MODIFY, 32'h7fff_ffff, 7'd1, 1'b0);
		add_cmd(CMD_MODIFY, 32'h8000_0000, 7'd16, 1'b0);
		add_cmd(CMD_MODIFY, 32'd9, 7'd17, 1'b0);
		add_cmd(CMD_MODIFY, 32'd9, 7'd0, 1'b0);
		add_cmd(CMD_FIND, 32'd123, 7'd0, 1'b0);
		add_cmd(CMD_POP, 32'd0, 7'd0, 1'b0);
		add_cmd(CMD_POP, 32'd0, 7'd0, 1'b0);

		// random: fill, drain, balanced and flood phases
		for (int i = 0; i < NUM_RANDOM; i++) begin
			phase = (i / 40) % 4;
			roll = $urandom_range(99);
			case (phase)
				0: cmd = roll < 55 ? CMD_PUSH : roll < 70 ? CMD_POP :
					roll < 85 ? CMD_MODIFY : CMD_FIND;
				1: cmd = roll < 15 ? CMD_PUSH : roll < 70 ? CMD_POP :
					roll < 85 ? CMD_MODIFY : CMD_FIND;
				2: cmd = cmd_t'(roll % 4);
				default: cmd = roll < 50 ? CMD_PUSH : roll < 60 ? CMD_POP :
					roll < 70 ? CMD_MODIFY : CMD_FIND;
			endcase
			if (phase == 3 && cmd == CMD_PUSH)
				val = key_pool[4];
			else if ($urandom_range(99) < 70)
				val = key_pool[$urandom_range(5)];
			else
				val = $urandom;
			if (cmd == CMD_MODIFY && gen_count != 0 && $urandom_range(99) < 75)
				pos = 7'($urandom_range(gen_count, 1));
			else
				pos = 7'($urandom_range(64));
			add_cmd(cmd, val, pos, (i % 97) == 50);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (QDEPTH + 8) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// queue one command and track the expected fill level for stimulus shaping
	task automatic add_cmd(cmd_t cmd, logic [31:0] value, logic [6:0] position,
			bit hold_for_drain);
		cmd_q.push_back('{cmd, value, position, hold_for_drain});
		if (cmd == CMD_PUSH && gen_count < QDEPTH)
			gen_count++;
		else if (cmd == CMD_POP && gen_count > 0)
			gen_count--;
	endtask

	// watchdog
	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

### files.f
+incdir+src
src/fqsu_pkg.sv
src/fqsu_cell.sv
src/fifo_queue_with_search_and_update.sv
test/tb.sv
